// ----- hw/rtl/slperm_pkg.sv -----
package slperm_pkg;

	localparam int DEF_MAX_SLOTS = 64;
	localparam int DEF_MAX_ROWS  = 16;

	// request and result field widths
	localparam int SLOT_W  = 6;
	localparam int ROW_W   = 4;
	localparam int CYCLE_W = 31;
	localparam int ENTRY_W = 8;
	localparam int SRC_W   = 6;

	// configuration registers
	localparam int SLOT_CNT_W = 7;
	localparam int ROW_CNT_W  = 5;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM_MODE  = 2'd2;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_SHUFFLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT_BACK = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT_FWD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REV_EVEN = 3'd3;

	localparam logic [ENTRY_W-1:0] ENTRY_INVALID = 8'hFF;

	// shuffle hash
	localparam int              HASH_W     = 32;
	localparam logic [HASH_W-1:0] HASH_MUL = 32'h6d2b79f5;
	localparam int              HASH_SHIFT = 15;

	// modulo unit: dividend bits consumed per cycle
	localparam int MOD_DIV_W  = 32;
	localparam int MOD_DVS_W  = 7;
	localparam int MOD_STEP   = 8;
	localparam int MOD_CYCLES = MOD_DIV_W / MOD_STEP;
	localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_TBL_MOD,
		ST_TBL_CHK,
		ST_ROT_MOD,
		ST_SH_INIT,
		ST_SH_HASH,
		ST_SH_MODST,
		ST_SH_MOD,
		ST_SH_WRI,
		ST_SH_WRJ,
		ST_SH_FIN,
		ST_SH_RES,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MS_TBL,
		MS_ROT,
		MS_SHUF
	} mod_sel_t;

	typedef enum logic [2:0] {
		RS_ZERO,
		RS_TBL,
		RS_ROT_BACK,
		RS_ROT_FWD,
		RS_REV,
		RS_SLOT,
		RS_ORDER
	} res_sel_t;

	typedef struct packed {
		logic     clr_wr;
		logic     cap_in;
		logic     tbl_wr_in;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     tbl_rd;
		logic     sh_seed;
		logic     ord_init;
		logic     hash_step;
		logic     ord_rd;
		logic     ord_wr_i;
		logic     ord_wr_j;
		logic     ord_fin_rd;
		logic     res_ld;
		res_sel_t res_sel;
		logic     out_ld;
	} cmd_t;

	typedef struct packed {
		logic              clear_last;
		logic              n_zero;
		logic              rows_nz;
		logic [MODE_W-1:0] mode;
		logic              mod_busy;
		logic              init_last;
		logic              i_zero;
		logic              i_one;
		logic              out_free;
	} sts_t;

endpackage

// ----- hw/rtl/slot_permutation_index.sv -----
// Maps a slot position and a cycle number to the source slot whose notes play there.
// A request with opcode 1 stores a signed entry into the permutation table and returns
// nothing. A query (opcode 0) returns one source_index. With no slots configured, or in
// reverse-even or identity mode with no rows configured, a query is decided in the decode
// state and its result passes through the result register to the output register. A table
// lookup and a rotation each wait on the shared modulo unit, which resolves 8 dividend bits
// per cycle. A shuffle query first lays out the order memory, then does one swap for each
// slot index from n-1 down to 1, each a hash multiply, a modulo, a two-port read and two
// writes through the single write port of the order memory. Requests are taken one at a
// time; the next one is accepted while a finished result still waits in the output
// register. After reset every entry of the table (1024 at the defaults) is swept to
// invalid, one entry per cycle; in_stall stays high during the sweep while configuration
// writes are taken as usual.
module slot_permutation_index #(
	parameter int MAX_SLOTS = slperm_pkg::DEF_MAX_SLOTS,
	parameter int MAX_ROWS  = slperm_pkg::DEF_MAX_ROWS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [slperm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slperm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [slperm_pkg::SLOT_W-1:0]         slot_index,
	input  logic [slperm_pkg::CYCLE_W-1:0]        cycle,
	input  logic [slperm_pkg::ROW_W-1:0]          row_index,
	input  logic signed [slperm_pkg::ENTRY_W-1:0] entry_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [slperm_pkg::SRC_W-1:0]          source_index
);

	slperm_pkg::cmd_t cmd;
	slperm_pkg::sts_t sts;

	slperm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	slperm_dpath #(
		.MAX_SLOTS (MAX_SLOTS),
		.MAX_ROWS  (MAX_ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.slot_index   (slot_index),
		.cycle        (cycle),
		.row_index    (row_index),
		.entry_value  (entry_value),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.source_index (source_index)
	);

endmodule

// ----- hw/rtl/slperm_mod.sv -----
module slperm_mod (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [slperm_pkg::MOD_DIV_W-1:0]    dividend,
	input  logic [slperm_pkg::MOD_DVS_W-1:0]    divisor,
	output logic                                busy,
	output logic [slperm_pkg::MOD_DVS_W-1:0]    rem
);

	logic                                busy_q;
	logic [slperm_pkg::MOD_CNT_W-1:0]    cnt_q;
	logic [slperm_pkg::MOD_DIV_W-1:0]    div_q;
	logic [slperm_pkg::MOD_DVS_W-1:0]    dvs_q;
	logic [slperm_pkg::MOD_DVS_W-1:0]    rem_q;
	logic [slperm_pkg::MOD_DVS_W-1:0]    r;
	logic [slperm_pkg::MOD_DVS_W-1:0]    rem_d;

	// restoring remainder, one dividend bit per step, MSB first
	always_comb begin
		r = rem_q;
		for (int k = 0; k < slperm_pkg::MOD_STEP; k++) begin
			r = {r[slperm_pkg::MOD_DVS_W-2:0], div_q[slperm_pkg::MOD_DIV_W-1-k]};
			if (r >= dvs_q) begin
				r = r - dvs_q;
			end
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + slperm_pkg::MOD_CNT_W'(1);
			if (cnt_q == slperm_pkg::MOD_CNT_W'(slperm_pkg::MOD_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << slperm_pkg::MOD_STEP;
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/slperm_dpath.sv -----
module slperm_dpath #(
	parameter int MAX_SLOTS = slperm_pkg::DEF_MAX_SLOTS,
	parameter int MAX_ROWS  = slperm_pkg::DEF_MAX_ROWS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [slperm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slperm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [slperm_pkg::SLOT_W-1:0]         slot_index,
	input  logic [slperm_pkg::CYCLE_W-1:0]        cycle,
	input  logic [slperm_pkg::ROW_W-1:0]          row_index,
	input  logic signed [slperm_pkg::ENTRY_W-1:0] entry_value,
	input  logic                                  out_stall,
	input  slperm_pkg::cmd_t                      cmd,
	output slperm_pkg::sts_t                      sts,
	output logic                                  out_valid,
	output logic [slperm_pkg::SRC_W-1:0]          source_index
);

	localparam int SW        = $clog2(MAX_SLOTS);
	localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW        = RW + SW;
	localparam int TBL_DEPTH = 2 ** AW;

	localparam int SCW = slperm_pkg::SLOT_CNT_W;
	localparam int HW  = slperm_pkg::HASH_W;
	localparam int EW  = slperm_pkg::ENTRY_W;

	// configuration
	logic [SCW-1:0]                      slot_count_q;
	logic [slperm_pkg::ROW_CNT_W-1:0]    row_count_q;
	logic [slperm_pkg::MODE_W-1:0]       perm_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			row_count_q  <= '0;
			perm_mode_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slperm_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data;
				slperm_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_data[slperm_pkg::ROW_CNT_W-1:0];
				slperm_pkg::CFG_PERM_MODE:  perm_mode_q  <= cfg_data[slperm_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SCW-1:0]                      n;
	logic [SCW-1:0]                      n_m1;
	logic [slperm_pkg::ROW_CNT_W-1:0]    rows;

	assign n    = (slot_count_q > SCW'(MAX_SLOTS)) ? SCW'(MAX_SLOTS) : slot_count_q;
	assign n_m1 = n - SCW'(1);
	assign rows = (32'(row_count_q) > 32'(MAX_ROWS)) ?
		slperm_pkg::ROW_CNT_W'(MAX_ROWS) : row_count_q;

	// captured query
	logic [slperm_pkg::SLOT_W-1:0]  slot_q;
	logic [slperm_pkg::CYCLE_W-1:0] cycle_q;
	logic [slperm_pkg::SLOT_W-1:0]  slot_c;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			slot_q  <= slot_index;
			cycle_q <= cycle;
		end
	end

	assign slot_c = ({1'b0, slot_q} > n_m1) ? n_m1[slperm_pkg::SLOT_W-1:0] : slot_q;

	// hash chain
	logic [HW-1:0] hash_q;
	logic [HW-1:0] hash_seed;
	logic [HW-1:0] hash_mix;
	logic [HW-1:0] hash_next;
	logic [HW-1:0] hash_mag;

	assign hash_seed = ({1'b0, cycle_q} + 32'd1) * slperm_pkg::HASH_MUL;
	assign hash_mix  = hash_q ^ (hash_q >> slperm_pkg::HASH_SHIFT);
	assign hash_next = hash_mix * (hash_q | 32'd1);
	assign hash_mag  = hash_q[HW-1] ? (~hash_q + 32'd1) : hash_q;

	// shuffle counters
	logic [SW-1:0] k_q;
	logic [SW-1:0] i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			k_q    <= '0;
			i_q    <= '0;
		end else begin
			if (cmd.sh_seed) begin
				hash_q <= hash_seed;
				k_q    <= '0;
				i_q    <= SW'(n_m1);
			end else begin
				if (cmd.hash_step) begin
					hash_q <= hash_next;
				end
				if (cmd.ord_init) begin
					k_q <= k_q + SW'(1);
				end
				if (cmd.ord_wr_j) begin
					i_q <= i_q - SW'(1);
				end
			end
		end
	end

	// modulo unit, shared by row select, rotation and shuffle
	logic [slperm_pkg::MOD_DIV_W-1:0] mod_dividend;
	logic [slperm_pkg::MOD_DVS_W-1:0] mod_divisor;
	logic                             mod_busy;
	logic [slperm_pkg::MOD_DVS_W-1:0] mod_rem;

	always_comb begin
		case (cmd.mod_sel)
			slperm_pkg::MS_TBL: begin
				mod_dividend = {1'b0, cycle_q};
				mod_divisor  = slperm_pkg::MOD_DVS_W'(rows);
			end
			slperm_pkg::MS_ROT: begin
				mod_dividend = {1'b0, cycle_q} + 32'd1;
				mod_divisor  = n;
			end
			default: begin
				mod_dividend = hash_mag;
				mod_divisor  = slperm_pkg::MOD_DVS_W'(i_q) + slperm_pkg::MOD_DVS_W'(1);
			end
		endcase
	end

	slperm_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// permutation table, swept to invalid after reset
	logic [EW-1:0] tbl_mem [TBL_DEPTH];
	logic [AW-1:0] clr_q;
	logic [EW-1:0] tbl_q;
	logic          wr_ok;
	logic          tbl_we;
	logic [AW-1:0] tbl_wa;
	logic [EW-1:0] tbl_wd;
	logic [AW-1:0] tbl_ra;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign wr_ok  = (32'(row_index) < 32'(MAX_ROWS)) && (32'(slot_index) < 32'(MAX_SLOTS));
	assign tbl_we = cmd.clr_wr || (cmd.tbl_wr_in && wr_ok);
	assign tbl_wa = cmd.clr_wr ? clr_q : {RW'(row_index), SW'(slot_index)};
	assign tbl_wd = cmd.clr_wr ? slperm_pkg::ENTRY_INVALID : entry_value;
	assign tbl_ra = {RW'(mod_rem), SW'(slot_c)};

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (cmd.tbl_rd) begin
			tbl_q <= tbl_mem[tbl_ra];
		end
	end

	// shuffle order: one write port, two read ports
	logic [SW-1:0] ord_mem [MAX_SLOTS];
	logic [SW-1:0] ord_a_q;
	logic [SW-1:0] ord_b_q;
	logic [SW-1:0] ord_j;
	logic [SW-1:0] ord_ra;
	logic          ord_we;
	logic [SW-1:0] ord_wa;
	logic [SW-1:0] ord_wd;

	assign ord_j  = SW'(mod_rem);
	assign ord_ra = cmd.ord_fin_rd ? SW'(slot_c) : i_q;

	always_comb begin
		ord_we = cmd.ord_init || cmd.ord_wr_i || cmd.ord_wr_j;
		if (cmd.ord_init) begin
			ord_wa = k_q;
			ord_wd = k_q;
		end else if (cmd.ord_wr_i) begin
			ord_wa = i_q;
			ord_wd = ord_b_q;
		end else begin
			ord_wa = ord_j;
			ord_wd = ord_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		if (cmd.ord_rd || cmd.ord_fin_rd) begin
			ord_a_q <= ord_mem[ord_ra];
		end
		if (cmd.ord_rd) begin
			ord_b_q <= ord_mem[ord_j];
		end
	end

	// result select
	logic [7:0]                    m8;
	logic [7:0]                    n8;
	logic [7:0]                    s8;
	logic [7:0]                    back_sum;
	logic [7:0]                    back_w;
	logic [7:0]                    fwd_sum;
	logic [7:0]                    fwd_w;
	logic [SCW-1:0]                rev;
	logic                          tbl_ok;
	logic [slperm_pkg::SRC_W-1:0]  res_d;
	logic [slperm_pkg::SRC_W-1:0]  res_q;

	assign m8       = 8'(mod_rem);
	assign n8       = 8'(n);
	assign s8       = 8'(slot_c);
	assign back_sum = s8 + n8 - m8;
	assign back_w   = (back_sum >= n8) ? back_sum - n8 : back_sum;
	assign fwd_sum  = s8 + m8;
	assign fwd_w    = (fwd_sum >= n8) ? fwd_sum - n8 : fwd_sum;
	assign rev      = n_m1 - SCW'(slot_c);
	assign tbl_ok   = !tbl_q[EW-1] && (tbl_q[EW-2:0] < n);

	always_comb begin
		case (cmd.res_sel)
			slperm_pkg::RS_ZERO:     res_d = '0;
			slperm_pkg::RS_TBL:      res_d = tbl_ok ? tbl_q[slperm_pkg::SRC_W-1:0] : slot_c;
			slperm_pkg::RS_ROT_BACK: res_d = back_w[slperm_pkg::SRC_W-1:0];
			slperm_pkg::RS_ROT_FWD:  res_d = fwd_w[slperm_pkg::SRC_W-1:0];
			slperm_pkg::RS_REV:      res_d = cycle_q[0] ? slot_c : rev[slperm_pkg::SRC_W-1:0];
			slperm_pkg::RS_ORDER:    res_d = slperm_pkg::SRC_W'(ord_a_q);
			default:                 res_d = slot_c;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_q <= res_d;
		end
	end

	// output register
	logic                          out_valid_q;
	logic [slperm_pkg::SRC_W-1:0]  source_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			source_index_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign source_index = source_index_q;

	assign sts.clear_last = (clr_q == AW'(TBL_DEPTH - 1));
	assign sts.n_zero     = (n == '0);
	assign sts.rows_nz    = (rows != '0);
	assign sts.mode       = perm_mode_q;
	assign sts.mod_busy   = mod_busy;
	assign sts.init_last  = (k_q == SW'(n_m1));
	assign sts.i_zero     = (i_q == '0);
	assign sts.i_one      = (i_q == SW'(1));
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

// ----- hw/rtl/slperm_ctrl.sv -----
module slperm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  slperm_pkg::sts_t  sts,
	output slperm_pkg::cmd_t  cmd,
	output logic              in_stall
);

	slperm_pkg::state_t st_q;
	slperm_pkg::state_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= slperm_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			slperm_pkg::ST_CLEAR: begin
				if (sts.clear_last) st_d = slperm_pkg::ST_IDLE;
			end
			slperm_pkg::ST_IDLE: begin
				if (in_valid && opcode == slperm_pkg::OP_QUERY) st_d = slperm_pkg::ST_DECIDE;
			end
			slperm_pkg::ST_DECIDE: begin
				if (sts.n_zero) begin
					st_d = slperm_pkg::ST_DONE;
				end else if (sts.rows_nz) begin
					st_d = slperm_pkg::ST_TBL_MOD;
				end else begin
					case (sts.mode) inside
						slperm_pkg::MODE_SHUFFLE:                           st_d = slperm_pkg::ST_SH_INIT;
						slperm_pkg::MODE_ROT_BACK, slperm_pkg::MODE_ROT_FWD: st_d = slperm_pkg::ST_ROT_MOD;
						default:                                            st_d = slperm_pkg::ST_DONE;
					endcase
				end
			end
			slperm_pkg::ST_TBL_MOD: begin
				if (!sts.mod_busy) st_d = slperm_pkg::ST_TBL_CHK;
			end
			slperm_pkg::ST_TBL_CHK: st_d = slperm_pkg::ST_DONE;
			slperm_pkg::ST_ROT_MOD: begin
				if (!sts.mod_busy) st_d = slperm_pkg::ST_DONE;
			end
			slperm_pkg::ST_SH_INIT: begin
				if (sts.init_last) begin
					st_d = sts.i_zero ? slperm_pkg::ST_SH_FIN : slperm_pkg::ST_SH_HASH;
				end
			end
			slperm_pkg::ST_SH_HASH:  st_d = slperm_pkg::ST_SH_MODST;
			slperm_pkg::ST_SH_MODST: st_d = slperm_pkg::ST_SH_MOD;
			slperm_pkg::ST_SH_MOD: begin
				if (!sts.mod_busy) st_d = slperm_pkg::ST_SH_WRI;
			end
			slperm_pkg::ST_SH_WRI: st_d = slperm_pkg::ST_SH_WRJ;
			slperm_pkg::ST_SH_WRJ: begin
				st_d = sts.i_one ? slperm_pkg::ST_SH_FIN : slperm_pkg::ST_SH_MODST;
			end
			slperm_pkg::ST_SH_FIN: st_d = slperm_pkg::ST_SH_RES;
			slperm_pkg::ST_SH_RES: st_d = slperm_pkg::ST_DONE;
			slperm_pkg::ST_DONE: begin
				if (sts.out_free) st_d = slperm_pkg::ST_IDLE;
			end
			default: st_d = slperm_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (st_q)
			slperm_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
			slperm_pkg::ST_IDLE: begin
				if (in_valid) begin
					// table writes land on the accept edge
					if (opcode == slperm_pkg::OP_WRITE) cmd.tbl_wr_in = 1'b1;
					else                                cmd.cap_in    = 1'b1;
				end
			end
			slperm_pkg::ST_DECIDE: begin
				if (sts.n_zero) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = slperm_pkg::RS_ZERO;
				end else if (sts.rows_nz) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = slperm_pkg::MS_TBL;
				end else begin
					case (sts.mode) inside
						slperm_pkg::MODE_SHUFFLE: cmd.sh_seed = 1'b1;
						slperm_pkg::MODE_ROT_BACK, slperm_pkg::MODE_ROT_FWD: begin
							cmd.mod_start = 1'b1;
							cmd.mod_sel   = slperm_pkg::MS_ROT;
						end
						slperm_pkg::MODE_REV_EVEN: begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = slperm_pkg::RS_REV;
						end
						default: begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = slperm_pkg::RS_SLOT;
						end
					endcase
				end
			end
			slperm_pkg::ST_TBL_MOD: begin
				if (!sts.mod_busy) cmd.tbl_rd = 1'b1;
			end
			slperm_pkg::ST_TBL_CHK: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = slperm_pkg::RS_TBL;
			end
			slperm_pkg::ST_ROT_MOD: begin
				if (!sts.mod_busy) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = (sts.mode == slperm_pkg::MODE_ROT_BACK) ?
						slperm_pkg::RS_ROT_BACK : slperm_pkg::RS_ROT_FWD;
				end
			end
			slperm_pkg::ST_SH_INIT: cmd.ord_init  = 1'b1;
			slperm_pkg::ST_SH_HASH: cmd.hash_step = 1'b1;
			slperm_pkg::ST_SH_MODST: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel   = slperm_pkg::MS_SHUF;
			end
			slperm_pkg::ST_SH_MOD: begin
				if (!sts.mod_busy) cmd.ord_rd = 1'b1;
			end
			slperm_pkg::ST_SH_WRI: cmd.ord_wr_i = 1'b1;
			slperm_pkg::ST_SH_WRJ: begin
				// advance the hash for the next swap alongside the second write
				cmd.ord_wr_j  = 1'b1;
				cmd.hash_step = 1'b1;
			end
			slperm_pkg::ST_SH_FIN: cmd.ord_fin_rd = 1'b1;
			slperm_pkg::ST_SH_RES: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = slperm_pkg::RS_ORDER;
			end
			slperm_pkg::ST_DONE: begin
				if (sts.out_free) cmd.out_ld = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_stall = (st_q != slperm_pkg::ST_IDLE);

`ifndef ASSERT_OFF
	a_out_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result loaded while output register is occupied");

	a_query_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == slperm_pkg::ST_IDLE && in_valid && opcode == slperm_pkg::OP_QUERY)
		|=> (st_q == slperm_pkg::ST_DECIDE))
		else $error("accepted query did not enter decode");

	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |-> !sts.mod_busy)
		else $error("modulo started while busy");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ord_wr_j |-> $past(cmd.ord_wr_i))
		else $error("second swap write without first");
`endif

endmodule
